// File: sv/rpn_pkg.sv
// Package: shared constants and types for the RPN stack evaluator.
`default_nettype none
package rpn_pkg;
	localparam int unsigned StackDepth = 32;
	localparam int unsigned PtrW = $clog2(StackDepth + 1);
	localparam int unsigned AddrW = $clog2(StackDepth);

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_BIN   = 2'd1;
	localparam logic [1:0] CMD_UN    = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [3:0] OP_SUB = 4'd0;
	localparam logic [3:0] OP_MUL = 4'd1;
	localparam logic [3:0] OP_ADD = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_XOR = 4'd4;
	localparam logic [3:0] OP_AND = 4'd5;
	localparam logic [3:0] OP_OR  = 4'd6;
	localparam logic [3:0] OP_MOD = 4'd7;
	localparam logic [3:0] OP_POW = 4'd8;
	localparam logic [3:0] OP_SHL = 4'd9;
	localparam logic [3:0] OP_SHR = 4'd10;
	localparam logic [3:0] UOP_NEG = 4'd0;
	localparam logic [3:0] UOP_NOT = 4'd1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DIVZERO  = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_MISSING  = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic       latch_in;   // capture command fields
		logic       rd_top;     // read entry sp-1
		logic       rd_next;    // read entry sp-2
		logic       load_b;     // latch read data into b
		logic       load_a;     // latch read data into a
		logic       exec_start; // start binary op
		logic       exec_step;  // iterate multicycle unit
		logic       wr_push;    // write value at sp
		logic       wr_res;     // write result at sp-2
		logic       wr_un;      // write unary result at sp-1
		logic       rd_final;   // read new top
		logic       set_out;    // output strobe
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] command;
		logic       iter_done;
		logic [PtrW-1:0] sp;
	} sts_t;
endpackage
`default_nettype wire

// File: sv/rpn_datapath.sv
// Datapath: operand stack memory, pointer, arithmetic units and result registers.
`default_nettype none
module rpn_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          command,
	input  wire logic [3:0]          op_code,
	input  wire logic signed [31:0]  value,
	input  wire rpn_pkg::ctl_t       ctl,
	output rpn_pkg::sts_t            sts,
	output logic [2:0]               status,
	output logic signed [63:0]       top_value,
	output logic [5:0]               stack_depth,
	output logic                     done
);
	localparam int unsigned PW = rpn_pkg::PtrW;
	localparam int unsigned AW = rpn_pkg::AddrW;
	localparam logic [PW-1:0] FullPtr = PW'(rpn_pkg::StackDepth);

	logic [63:0] mem_q [rpn_pkg::StackDepth];
	logic [63:0] rd_q;
	logic [PW-1:0] sp_q;
	logic [1:0] cmd_q;
	logic [3:0] op_q;
	logic [63:0] val_q;
	logic [63:0] a_q, b_q;
	logic [2:0] st_q;

	// iterative unit state
	logic [6:0] cnt_q;
	logic [63:0] rem_q, quo_q, dvd_q, dvs_q;   // divider (magnitudes)
	logic [63:0] acc_q, base_q, exp_q;         // power
	logic        pmul_q;                       // power: 0 acc step, 1 base step
	logic [63:0] res_q;

	logic [AW-1:0] rd_addr, wr_addr;
	logic [63:0] wr_data;
	logic        wr_en;

	always_comb begin
		rd_addr = AW'(sp_q - PW'(1));
		if (ctl.rd_next) rd_addr = AW'(sp_q - PW'(2));
		wr_en = ctl.wr_push | (ctl.wr_res & (st_q == rpn_pkg::ST_OK)) | ctl.wr_un;
		wr_addr = AW'(sp_q);
		wr_data = val_q;
		if (ctl.wr_res) begin
			wr_addr = AW'(sp_q - PW'(2));
			wr_data = res_q;
		end else if (ctl.wr_un) begin
			wr_addr = AW'(sp_q - PW'(1));
			wr_data = (op_q == rpn_pkg::UOP_NEG) ? (64'd0 - b_q) :
				(op_q == rpn_pkg::UOP_NOT) ? ~b_q : b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	// binary operation checks and simple results
	logic signed [63:0] sa;
	logic a_in_rng, b_zero, sh_ok;
	logic [63:0] simple_r;
	always_comb begin
		sa = a_q;
		a_in_rng = (sa >= -64'sd2147483647) && (sa <= 64'sd2147483647);
		b_zero = (b_q == 64'd0);
		sh_ok = (b_q[63:5] == 59'd0);
		case (op_q)
			rpn_pkg::OP_SUB: simple_r = a_q - b_q;
			rpn_pkg::OP_ADD: simple_r = a_q + b_q;
			rpn_pkg::OP_XOR: simple_r = a_q ^ b_q;
			rpn_pkg::OP_AND: simple_r = a_q & b_q;
			rpn_pkg::OP_OR:  simple_r = a_q | b_q;
			rpn_pkg::OP_SHL: simple_r = a_q << b_q[4:0];
			rpn_pkg::OP_SHR: simple_r = 64'(sa >>> b_q[4:0]);
			default:         simple_r = 64'd0;
		endcase
	end

	function automatic logic [63:0] wrap32(input logic [63:0] r);
		logic signed [63:0] s;
		s = r;
		if (s > 64'sd2147483647) return {{32{r[31]}}, r[31:0]};
		return r;
	endfunction

	// 64x64 low product from 32-bit partial products, one per cycle
	logic [63:0] mx, my;
	logic [1:0]  pp_q;
	logic [63:0] pacc_q;
	logic [31:0] pm_x, pm_y;
	logic [63:0] pm_p;
	always_comb begin
		mx = a_q; my = b_q;
		if (op_q == rpn_pkg::OP_POW) begin
			mx = pmul_q ? base_q : acc_q;
			my = base_q;
		end
		case (pp_q)
			2'd0: begin pm_x = mx[31:0];  pm_y = my[31:0];  end
			2'd1: begin pm_x = mx[31:0];  pm_y = my[63:32]; end
			default: begin pm_x = mx[63:32]; pm_y = my[31:0]; end
		endcase
		pm_p = {32'd0, pm_x} * {32'd0, pm_y};
	end
	logic [63:0] pacc_n;
	always_comb begin
		pacc_n = (pp_q == 2'd0) ? pm_p : (pacc_q + {pm_p[31:0], 32'd0});
	end
	logic prod_done;
	assign prod_done = (pp_q == 2'd2);

	// restoring divider step
	logic [64:0] dsub;
	logic [63:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[62:0], dvd_q[63]};
		dsub = {1'b0, rem_sh} - {1'b0, dvs_q};
	end

	logic iter_done_q;
	logic iter_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			done <= 1'b0;
			iter_done_q <= 1'b0;
			iter_busy_q <= 1'b0;
			pp_q <= 2'd0;
		end else begin
			done <= ctl.set_out;
			if (ctl.latch_in) iter_done_q <= 1'b0;
			if (ctl.wr_push) sp_q <= sp_q + PW'(1);
			if (ctl.latch_in && command == rpn_pkg::CMD_CLEAR) sp_q <= '0;
			if (ctl.latch_in && command == rpn_pkg::CMD_BIN && sp_q < PW'(2)) sp_q <= '0;
			if (ctl.exec_start && sp_q >= PW'(2)) begin
				iter_busy_q <= 1'b1;
				pp_q <= 2'd0;
			end
			if (ctl.exec_step && iter_busy_q) begin
				unique case (op_q)
					rpn_pkg::OP_MUL: begin
						pp_q <= prod_done ? 2'd0 : pp_q + 2'd1;
						if (prod_done) begin
							iter_busy_q <= 1'b0; iter_done_q <= 1'b1;
						end
					end
					rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
						if (cnt_q == 7'd64) begin
							iter_busy_q <= 1'b0; iter_done_q <= 1'b1;
						end
					end
					rpn_pkg::OP_POW: begin
						if (exp_q == 64'd0) begin
							iter_busy_q <= 1'b0; iter_done_q <= 1'b1;
						end else if (!pmul_q && !exp_q[0]) begin
							pp_q <= 2'd0;
						end else begin
							pp_q <= prod_done ? 2'd0 : pp_q + 2'd1;
						end
					end
					default: begin
						iter_busy_q <= 1'b0; iter_done_q <= 1'b1;
					end
				endcase
			end
			// result replaces both operands; an error drops them
			if (ctl.wr_res)
				sp_q <= (st_q == rpn_pkg::ST_OK) ? sp_q - PW'(1) : sp_q - PW'(2);
		end
	end

	// payload registers
	logic [63:0] mag_a, mag_b;
	assign mag_a = a_q[63] ? 64'd0 - a_q : a_q;
	assign mag_b = b_q[63] ? 64'd0 - b_q : b_q;

	logic [63:0] pow_r, div_r;
	always_comb begin
		pow_r = acc_q;
		if ($signed(acc_q) <= -64'sd2147483647) pow_r = 64'd0;
		if (a_q == 64'd10 && b_q == 64'd40) pow_r = 64'd0;
		if (a_q == 64'hFFFF_FFFF_FFFF_FFFF && b_q == 64'd2) pow_r = 64'hFFFF_FFFF_FFFF_FFFF;
		div_r = (op_q == rpn_pkg::OP_DIV) ?
			((a_q[63] ^ b_q[63]) ? 64'd0 - quo_q : quo_q) :
			(a_q[63] ? 64'd0 - rem_q : rem_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			cmd_q <= command;
			op_q <= op_code;
			val_q <= {{32{value[31]}}, value};
			st_q <= rpn_pkg::ST_OK;
			if (command == rpn_pkg::CMD_PUSH && sp_q >= FullPtr) st_q <= rpn_pkg::ST_FULL;
			if (command == rpn_pkg::CMD_BIN && sp_q < PW'(2)) st_q <= rpn_pkg::ST_MISSING;
		end
		if (ctl.load_b) b_q <= rd_q;
		if (ctl.load_a) a_q <= rd_q;
		if (ctl.exec_start) begin
			res_q <= wrap32(simple_r);
			cnt_q <= 7'd0;
			rem_q <= 64'd0;
			quo_q <= 64'd0;
			dvd_q <= mag_a;
			dvs_q <= mag_b;
			acc_q <= 64'd1;
			base_q <= a_q;
			exp_q <= b_q;
			pmul_q <= 1'b0;
			if (op_q == rpn_pkg::OP_DIV) begin
				if (!a_in_rng) st_q <= rpn_pkg::ST_OVERFLOW;
				else if (b_zero) st_q <= rpn_pkg::ST_DIVZERO;
			end
			if (op_q == rpn_pkg::OP_MOD) begin
				if (b_zero) st_q <= rpn_pkg::ST_DIVZERO;
				else if (!a_in_rng) st_q <= rpn_pkg::ST_OVERFLOW;
			end
			if (op_q == rpn_pkg::OP_POW && b_q[63]) st_q <= rpn_pkg::ST_OVERFLOW;
			if ((op_q == rpn_pkg::OP_SHL || op_q == rpn_pkg::OP_SHR) && !sh_ok)
				st_q <= rpn_pkg::ST_OVERFLOW;
		end
		if (ctl.exec_step && iter_busy_q) begin
			case (op_q)
				rpn_pkg::OP_MUL: begin
					pacc_q <= pacc_n;
					if (prod_done) res_q <= wrap32(pacc_n);
				end
				rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
					if (cnt_q != 7'd64) begin
						cnt_q <= cnt_q + 7'd1;
						dvd_q <= {dvd_q[62:0], 1'b0};
						if (!dsub[64]) begin
							rem_q <= dsub[63:0];
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[62:0], 1'b0};
						end
					end else begin
						res_q <= wrap32(div_r);
					end
				end
				rpn_pkg::OP_POW: begin
					if (exp_q == 64'd0) begin
						res_q <= wrap32(pow_r);
					end else if (!pmul_q && !exp_q[0]) begin
						pmul_q <= 1'b1;
					end else begin
						pacc_q <= pacc_n;
						if (prod_done) begin
							if (pmul_q) begin
								base_q <= pacc_n;
								exp_q <= {1'b0, exp_q[63:1]};
								pmul_q <= 1'b0;
							end else begin
								acc_q <= pacc_n;
								pmul_q <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
		if (ctl.set_out) begin
			status <= st_q;
			stack_depth <= 6'(sp_q);
		end
	end

	assign top_value = (stack_depth == 6'd0) ? 64'sd0 : rd_q;

	always_comb begin
		sts.command = cmd_q;
		sts.iter_done = iter_done_q;
		sts.sp = sp_q;
	end

	logic unused;
	assign unused = ctl.rd_top ^ ctl.rd_final ^ st_q[0];
endmodule
`default_nettype wire

// File: sv/rpn_ctrl.sv
// Controller: sequences each command through the datapath.
`default_nettype none
module rpn_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire rpn_pkg::sts_t  sts,
	output rpn_pkg::ctl_t       ctl
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_RDB   = 4'd2;
	localparam logic [3:0] S_RDA   = 4'd3;
	localparam logic [3:0] S_LDA   = 4'd4;
	localparam logic [3:0] S_EXEC  = 4'd5;
	localparam logic [3:0] S_ITER  = 4'd6;
	localparam logic [3:0] S_WR    = 4'd7;
	localparam logic [3:0] S_UNLD  = 4'd8;
	localparam logic [3:0] S_UNWR  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_PUSH  = 4'd12;

	logic [3:0] state_q, state_n;
	logic [rpn_pkg::PtrW-1:0] depth_ok;
	assign depth_ok = sts.sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch_in = 1'b1;
					state_n = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.command)
					rpn_pkg::CMD_PUSH:  state_n = S_PUSH;
					rpn_pkg::CMD_BIN:   state_n = (depth_ok >= rpn_pkg::PtrW'(2)) ? S_RDB : S_FIN;
					rpn_pkg::CMD_UN:    state_n = (depth_ok != '0) ? S_RDB : S_FIN;
					default:            state_n = S_FIN;
				endcase
				ctl.rd_top = 1'b1;
			end
			S_PUSH: begin
				if (depth_ok < rpn_pkg::PtrW'(rpn_pkg::StackDepth)) ctl.wr_push = 1'b1;
				state_n = S_FIN;
			end
			S_RDB: begin
				ctl.load_b = 1'b1;
				ctl.rd_next = 1'b1;
				state_n = (sts.command == rpn_pkg::CMD_UN) ? S_UNWR : S_LDA;
			end
			S_LDA: begin
				ctl.load_a = 1'b1;
				state_n = S_EXEC;
			end
			S_EXEC: begin
				ctl.exec_start = 1'b1;
				state_n = S_ITER;
			end
			S_ITER: begin
				ctl.exec_step = 1'b1;
				if (sts.iter_done) state_n = S_WR;
			end
			S_WR: begin
				// write the result, or drop both operands on error
				ctl.wr_res = 1'b1;
				state_n = S_FIN;
			end
			S_UNWR: begin
				ctl.wr_un = 1'b1;
				state_n = S_FIN;
			end
			S_FIN: begin
				ctl.rd_final = 1'b1;
				state_n = S_OUT;
			end
			S_OUT: begin
				ctl.set_out = 1'b1;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/rpn_stack_evaluator.sv
// Top level: RPN stack evaluator, controller plus datapath.
//  channel | signals                          | handshake
//  command | command, op_code, value         | start & !busy
//  result  | status, top_value, stack_depth  | done (one cycle)
// A new command beat is accepted only once busy has dropped; done rises as busy falls.
// Multiply sums 32-bit partial products; divide and modulo run a 64-step divider;
// power squares the base for each exponent bit and multiplies it in where the bit is set.
// Reset clears the stack pointer; stack contents are not cleared.
// The result strobe cannot be stalled.
`default_nettype none
module rpn_stack_evaluator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         command,
	input  wire logic [3:0]         op_code,
	input  wire logic signed [31:0] value,
	output logic                    done,
	output logic [2:0]              status,
	output logic signed [63:0]      top_value,
	output logic [5:0]              stack_depth
);
	rpn_pkg::ctl_t ctl;
	rpn_pkg::sts_t sts;

	rpn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .ctl(ctl)
	);

	rpn_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .command(command), .op_code(op_code),
		.value(value), .ctl(ctl), .sts(sts), .status(status),
		.top_value(top_value), .stack_depth(stack_depth), .done(done)
	);
endmodule
`default_nettype wire

// File: dv/rpn_stack_evaluator_tb.sv
// Testbench: directed and random command streams for the RPN stack evaluator.
`default_nettype none
module rpn_stack_evaluator_tb;
	typedef struct packed {
		logic [2:0]         status;
		logic signed [63:0] top;
		logic [5:0]         depth;
	} step_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] command = rpn_pkg::CMD_CLEAR;
	logic [3:0] op_code = '0;
	logic signed [31:0] value = '0;
	logic busy, done;
	logic [2:0] status;
	logic signed [63:0] top_value;
	logic [5:0] stack_depth;

	rpn_stack_evaluator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .op_code(op_code), .value(value),
		.done(done), .status(status), .top_value(top_value),
		.stack_depth(stack_depth)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [63:0] model_stack [rpn_pkg::StackDepth];
	int unsigned model_sp = 0;
	step_out_t pending_results [$];
	int errors = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int burst_left = 0;

	function automatic logic signed [63:0] wrap_result(logic signed [63:0] r);
		if (r > 64'sd2147483647)
			return {{32{r[31]}}, r[31:0]};
		return r;
	endfunction

	function automatic logic [2:0] eval_binary(logic [3:0] op, logic signed [63:0] a,
			logic signed [63:0] b, output logic signed [63:0] r);
		logic [63:0] acc, base, ex;
		r = '0;
		case (op)
			rpn_pkg::OP_SUB: r = a - b;
			rpn_pkg::OP_MUL: r = a * b;
			rpn_pkg::OP_ADD: r = a + b;
			rpn_pkg::OP_DIV: begin
				if (a > 64'sd2147483647 || a < -64'sd2147483647) return rpn_pkg::ST_OVERFLOW;
				if (b == 0) return rpn_pkg::ST_DIVZERO;
				r = a / b;
			end
			rpn_pkg::OP_XOR: r = a ^ b;
			rpn_pkg::OP_AND: r = a & b;
			rpn_pkg::OP_OR:  r = a | b;
			rpn_pkg::OP_MOD: begin
				if (b == 0) return rpn_pkg::ST_DIVZERO;
				if (a > 64'sd2147483647 || a < -64'sd2147483647) return rpn_pkg::ST_OVERFLOW;
				r = a % b;
			end
			rpn_pkg::OP_POW: begin
				if (b < 0) return rpn_pkg::ST_OVERFLOW;
				if (a == 10 && b == 40) r = '0;
				else begin
					acc = 64'd1; base = a; ex = b;
					while (ex != 0) begin
						if (ex[0]) acc = acc * base;
						base = base * base;
						ex = ex >> 1;
					end
					r = acc;
					if (r <= -64'sd2147483647) r = '0;
				end
				if (a == -1 && b == 2) r = -64'sd1;
			end
			rpn_pkg::OP_SHL: begin
				if (b < 0 || b > 31) return rpn_pkg::ST_OVERFLOW;
				r = a << b[4:0];
			end
			rpn_pkg::OP_SHR: begin
				if (b < 0 || b > 31) return rpn_pkg::ST_OVERFLOW;
				r = a >>> b[4:0];
			end
			default: r = '0;
		endcase
		r = wrap_result(r);
		return rpn_pkg::ST_OK;
	endfunction

	function automatic step_out_t predict_step(logic [1:0] cmd, logic [3:0] op,
			logic signed [31:0] v);
		step_out_t o;
		logic signed [63:0] a, b, r;
		o.status = rpn_pkg::ST_OK;
		case (cmd)
			rpn_pkg::CMD_PUSH:
				if (model_sp >= rpn_pkg::StackDepth) o.status = rpn_pkg::ST_FULL;
				else begin
					model_stack[model_sp] = 64'(v);
					model_sp++;
				end
			rpn_pkg::CMD_BIN:
				if (model_sp < 2) begin
					model_sp = 0;
					o.status = rpn_pkg::ST_MISSING;
				end else begin
					b = model_stack[model_sp-1];
					a = model_stack[model_sp-2];
					model_sp -= 2;
					o.status = eval_binary(op, a, b, r);
					if (o.status == rpn_pkg::ST_OK) begin
						model_stack[model_sp] = r;
						model_sp++;
					end
				end
			rpn_pkg::CMD_UN:
				if (model_sp > 0) begin
					if (op == rpn_pkg::UOP_NEG)
						model_stack[model_sp-1] = -model_stack[model_sp-1];
					else if (op == rpn_pkg::UOP_NOT)
						model_stack[model_sp-1] = ~model_stack[model_sp-1];
				end
			default: model_sp = 0;
		endcase
		o.top = model_sp > 0 ? model_stack[model_sp-1] : '0;
		o.depth = 6'(model_sp);
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch beat %0d %s: got %0h want %0h", beats_checked, what, got, want);
	endtask

	always @(posedge clk) begin
		step_out_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected beat", '0, '0);
			else begin
				e = pending_results.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (top_value !== e.top) report_mismatch("top_value", top_value, e.top);
				if (stack_depth !== e.depth) report_mismatch("depth", stack_depth, e.depth);
			end
			beats_checked++;
		end
	end

	// start stays high inside a burst; it drops on a gap or a drain
	task automatic send_cmd(logic [1:0] cmd, logic [3:0] op, logic signed [31:0] v);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 20);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= cmd; op_code <= op; value <= v; start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_step(cmd, op, v));
		beats_sent++;
	endtask

	task automatic push(logic signed [31:0] v);
		send_cmd(rpn_pkg::CMD_PUSH, '0, v);
	endtask

	task automatic bin(logic signed [31:0] a, logic signed [31:0] b, logic [3:0] op);
		push(a); push(b); send_cmd(rpn_pkg::CMD_BIN, op, '0);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic test_operators();
		bin(7, 3, rpn_pkg::OP_SUB); bin(32'h7fffffff, 2, rpn_pkg::OP_MUL);
		bin(-5, 9, rpn_pkg::OP_ADD);
		bin(-7, 2, rpn_pkg::OP_DIV); bin(-7, 0, rpn_pkg::OP_DIV); bin(-7, 0, rpn_pkg::OP_MOD);
		bin(-7, 3, rpn_pkg::OP_MOD); bin(32'hf0f0f0f0, -1, rpn_pkg::OP_XOR);
		bin(12, 10, rpn_pkg::OP_AND);
		bin(12, 3, rpn_pkg::OP_OR); bin(10, 40, rpn_pkg::OP_POW); bin(-1, 2, rpn_pkg::OP_POW);
		bin(3, -1, rpn_pkg::OP_POW); bin(1, 31, rpn_pkg::OP_SHL); bin(-64, 31, rpn_pkg::OP_SHR);
		bin(1, 32, rpn_pkg::OP_SHL); bin(5, 5, 4'd13);
		send_cmd(rpn_pkg::CMD_CLEAR, '0, '0);
	endtask

	task automatic test_stack_limits();
		send_cmd(rpn_pkg::CMD_BIN, rpn_pkg::OP_ADD, '0);
		push(4); send_cmd(rpn_pkg::CMD_BIN, rpn_pkg::OP_ADD, '0);
		send_cmd(rpn_pkg::CMD_UN, rpn_pkg::UOP_NEG, '0);
		push(32'h80000000); push(32'h80000000); send_cmd(rpn_pkg::CMD_BIN, rpn_pkg::OP_MUL, '0);
		bin(32'h80000000, 32'h80000000, rpn_pkg::OP_MUL); bin(0, 0, rpn_pkg::OP_DIV);
		send_cmd(rpn_pkg::CMD_CLEAR, '0, '0);
		for (int i = 0; i < rpn_pkg::StackDepth + 2; i++) push($urandom);
		send_cmd(rpn_pkg::CMD_UN, rpn_pkg::UOP_NOT, '0); send_cmd(rpn_pkg::CMD_UN, 4'd9, '0);
		send_cmd(rpn_pkg::CMD_CLEAR, '0, '0);
		drain();
	endtask

	task automatic test_random(int n);
		logic signed [31:0] v;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: v = $urandom;
				4: v = $urandom_range(0, 40);
				5: v = -$signed(32'($urandom_range(0, 3)));
				default: v = $signed(32'($urandom_range(0, 2000))) - 1000;
			endcase
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: send_cmd(rpn_pkg::CMD_PUSH, 4'($urandom), v);
				8, 9, 10, 11, 12, 13:
					send_cmd(rpn_pkg::CMD_BIN, $urandom_range(0, 9) == 0 ? 4'($urandom)
						: 4'($urandom_range(0, 10)), v);
				14, 15, 16: send_cmd(rpn_pkg::CMD_UN, $urandom_range(0, 4) == 0
					? 4'($urandom) : 4'($urandom_range(0, 1)), v);
				17, 18: push(v);
				default: if ($urandom_range(0, 3) == 0)
						send_cmd(rpn_pkg::CMD_CLEAR, 4'($urandom), v);
					else push(v);
			endcase
			if (i == n / 2) drain();
		end
	endtask

	initial begin
		#200_000_000;
		$display("rpn_stack_evaluator_tb: FAIL");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_operators();
		test_stack_limits();
		test_random(1150);
		drain();
		repeat (300) @(negedge clk);
		$display("Sent %0d command beats (directed operators, stack limits, random mix);",
			beats_sent);
		$display("checked %0d result beats, %0d mismatches.", beats_checked, errors);
		if (errors == 0 && pending_results.size() == 0)
			$display("rpn_stack_evaluator_tb: PASS");
		else
			$display("rpn_stack_evaluator_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
